>>> rtl/keypad_key_event_engine_defines.svh
// Assertion macros shared by the keypad key event engine RTL.
`ifndef KEYPAD_KEY_EVENT_ENGINE_DEFINES_SVH
`define KEYPAD_KEY_EVENT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KKEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KKEE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad engine check failed");

`endif

>>> rtl/kkee_pkg.sv
// Shared types and constants of the keypad key event engine.
package kkee_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int SCAN_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int POWER_W = 8;

    typedef enum logic [1:0] {
        MODE_POLL  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_POWER = 2'd3
    } mode_t;

    localparam logic [KIND_W-1:0] KIND_AUTO    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SINGLE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LONG    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PERSIST = 3'd4;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0]  CHAR_POWER   = 8'h50;
    localparam logic [CHAR_W-1:0]  CHAR_SHIFT   = 8'hFF;
    localparam logic [CHAR_W-1:0]  CASE_BIT     = 8'h20;
    localparam logic [7:0]         REPEAT_MAX   = 8'hFF;
    localparam logic [7:0]         LONG_PRESS_N = 8'd5;
    localparam logic [POWER_W-1:0] POWER_MAX    = 8'd100;
    localparam logic [POWER_W-1:0] POWER_RESET  = 8'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic [KIND_W-1:0] kind;
        logic [SCAN_W-1:0] scan;
    } key_entry_t;

    localparam int ENTRY_W = $bits(key_entry_t);

    typedef struct packed {
        logic capture;
        logic start;
        logic step;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  search_done;
    } dp_status_t;

endpackage

>>> rtl/kkee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kkee_ram #(
    parameter int WIDTH = kkee_pkg::ENTRY_W,
    parameter int DEPTH = kkee_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/kkee_datapath.sv
// Datapath: item registers, key table search, hold state and result registers.
module kkee_datapath #(
    parameter int TABLE_DEPTH = kkee_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kkee_pkg::dp_cmd_t             cmd,
    output kkee_pkg::dp_status_t          status,
    input  logic                          power_keys_enable,
    input  logic [1:0]                    mode,
    input  logic [kkee_pkg::SCAN_W-1:0]   scan_code,
    input  logic [kkee_pkg::CHAR_W-1:0]   key_char,
    input  logic [7:0]                    key_kind,
    input  logic [kkee_pkg::POWER_W-1:0]  power_setting,
    output logic                          emit,
    output logic [kkee_pkg::CHAR_W-1:0]   emitted_code,
    output logic                          strobe_hold,
    output logic [kkee_pkg::POWER_W-1:0]  power_level
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W_L = kkee_pkg::ENTRY_W;

    // captured item
    kkee_pkg::mode_t                 mode_reg;
    logic [kkee_pkg::SCAN_W-1:0]     scan_reg;
    logic [kkee_pkg::CHAR_W-1:0]     char_reg;
    logic [kkee_pkg::KIND_W-1:0]     kind_reg;
    logic [kkee_pkg::POWER_W-1:0]    pset_reg;

    // persistent state
    logic [CW-1:0]                   entry_count_reg, entry_count_next;
    logic [kkee_pkg::SCAN_W-1:0]     shift_code_reg, shift_code_next;
    logic [kkee_pkg::CHAR_W-1:0]     last_key_reg, last_key_next;
    logic [7:0]                      repeat_count_reg, repeat_count_next;
    logic                            long_seen_reg, long_seen_next;
    logic                            holding_reg, holding_next;
    logic                            pstrobe_reg, pstrobe_next;
    logic [kkee_pkg::POWER_W-1:0]    power_reg, power_next;

    // search
    logic [AW-1:0]                   rd_idx_reg;
    logic [CW-1:0]                   left_reg;
    logic                            pending_reg;
    logic                            hit_reg;
    logic                            done_reg;
    kkee_pkg::key_entry_t            entry_reg;
    kkee_pkg::key_entry_t            rd_entry;
    logic [ENTRY_W_L-1:0]            rd_data;
    logic [CW-1:0]                   top_idx;
    logic                            match;

    // result registers
    logic                            emit_reg;
    logic [kkee_pkg::CHAR_W-1:0]     code_reg;
    logic                            strobe_reg;
    logic [kkee_pkg::POWER_W-1:0]    out_power_reg;

    // exec results
    logic                            emit_next;
    logic [kkee_pkg::CHAR_W-1:0]     code_next;
    logic                            do_end;
    logic                            table_we;
    kkee_pkg::key_entry_t            new_entry;
    logic [kkee_pkg::KIND_W-1:0]     kind_norm;

    kkee_ram #(
        .WIDTH (ENTRY_W_L),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (entry_count_reg[AW-1:0]),
        .wdata (new_entry),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    assign rd_entry = kkee_pkg::key_entry_t'(rd_data);
    assign match    = pending_reg && (rd_entry.scan == scan_reg);
    assign top_idx  = entry_count_reg - CW'(1);

    assign kind_norm = (key_kind >= 8'd1 && key_kind <= 8'd4) ? key_kind[2:0]
                                                               : kkee_pkg::KIND_SINGLE;

    assign new_entry.code = char_reg;
    assign new_entry.kind = kind_reg;
    assign new_entry.scan = scan_reg;

    assign status.mode        = mode_reg;
    assign status.search_done = done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= kkee_pkg::mode_t'(mode);
            scan_reg <= scan_code;
            char_reg <= key_char;
            kind_reg <= kind_norm;
            pset_reg <= power_setting;
        end
        if (cmd.step && !done_reg && match)
        begin
            entry_reg <= rd_entry;
        end
        if (cmd.exec)
        begin
            emit_reg      <= emit_next;
            code_reg      <= code_next;
            strobe_reg    <= pstrobe_next;
            out_power_reg <= power_next;
        end
    end

    // Walk the table from the newest entry down, one read issued per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            left_reg    <= '0;
            pending_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (cmd.start)
        begin
            rd_idx_reg  <= top_idx[AW-1:0];
            left_reg    <= (scan_reg == '0) ? '0 : entry_count_reg;
            pending_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (cmd.step && !done_reg)
        begin
            if (match)
            begin
                hit_reg     <= 1'b1;
                done_reg    <= 1'b1;
                pending_reg <= 1'b0;
            end
            else if (left_reg != '0)
            begin
                rd_idx_reg  <= rd_idx_reg - AW'(1);
                left_reg    <= left_reg - CW'(1);
                pending_reg <= 1'b1;
            end
            else
            begin
                pending_reg <= 1'b0;
                done_reg    <= !pending_reg;
            end
        end
    end

    always_comb
    begin
        entry_count_next  = entry_count_reg;
        shift_code_next   = shift_code_reg;
        last_key_next     = last_key_reg;
        repeat_count_next = repeat_count_reg;
        long_seen_next    = long_seen_reg;
        holding_next      = holding_reg;
        pstrobe_next      = pstrobe_reg;
        power_next        = power_reg;
        emit_next         = 1'b0;
        code_next         = '0;
        do_end            = 1'b0;
        table_we          = 1'b0;
        case (mode_reg)
            kkee_pkg::MODE_POLL:
            begin
                if (!hit_reg)
                begin
                    do_end = holding_reg;
                end
                else
                begin
                    if (!holding_reg)
                    begin
                        holding_next      = 1'b1;
                        last_key_next     = '0;
                        repeat_count_next = '0;
                        long_seen_next    = 1'b0;
                        pstrobe_next      = 1'b0;
                    end
                    // a different key drops the counters of the previous one
                    if (last_key_next != '0 && entry_reg.code != last_key_next)
                    begin
                        repeat_count_next = '0;
                        long_seen_next    = 1'b0;
                        pstrobe_next      = 1'b0;
                    end
                    case (entry_reg.kind)
                        kkee_pkg::KIND_LONG:
                        begin
                            long_seen_next = 1'b1;
                            if (repeat_count_next != kkee_pkg::REPEAT_MAX)
                            begin
                                repeat_count_next = repeat_count_next + 8'd1;
                            end
                        end
                        kkee_pkg::KIND_AUTO:
                        begin
                            emit_next = 1'b1;
                            code_next = entry_reg.code;
                            if (repeat_count_next != kkee_pkg::REPEAT_MAX)
                            begin
                                repeat_count_next = repeat_count_next + 8'd1;
                            end
                        end
                        kkee_pkg::KIND_PERSIST:
                        begin
                            pstrobe_next = 1'b1;
                        end
                        default:
                        begin
                            if (last_key_next != entry_reg.code)
                            begin
                                emit_next = 1'b1;
                                code_next = entry_reg.code;
                            end
                        end
                    endcase
                    last_key_next = entry_reg.code;
                    if (power_keys_enable)
                    begin
                        if (entry_reg.code == kkee_pkg::CHAR_MINUS && power_reg != '0)
                        begin
                            power_next = power_reg - 8'd1;
                        end
                        else if (entry_reg.code == kkee_pkg::CHAR_PLUS &&
                                 power_reg < kkee_pkg::POWER_MAX)
                        begin
                            power_next = power_reg + 8'd1;
                        end
                    end
                    do_end = (entry_reg.scan == shift_code_reg);
                end
                // end of hold: its pulse replaces any pulse of this item
                if (do_end)
                begin
                    pstrobe_next = 1'b0;
                    holding_next = 1'b0;
                    if (power_keys_enable && (last_key_next == kkee_pkg::CHAR_MINUS ||
                                              last_key_next == kkee_pkg::CHAR_PLUS))
                    begin
                        emit_next = 1'b1;
                        code_next = kkee_pkg::CHAR_POWER;
                    end
                    else if (long_seen_next)
                    begin
                        emit_next = 1'b1;
                        code_next = (repeat_count_next < kkee_pkg::LONG_PRESS_N)
                                    ? (last_key_next | kkee_pkg::CASE_BIT) : last_key_next;
                    end
                end
            end
            kkee_pkg::MODE_ADD:
            begin
                if (entry_count_reg < CW'(TABLE_DEPTH))
                begin
                    table_we         = 1'b1;
                    entry_count_next = entry_count_reg + CW'(1);
                    if (char_reg == kkee_pkg::CHAR_SHIFT)
                    begin
                        shift_code_next = scan_reg;
                    end
                end
            end
            kkee_pkg::MODE_CLEAR:
            begin
                entry_count_next = '0;
                shift_code_next  = '0;
            end
            kkee_pkg::MODE_POWER:
            begin
                power_next = pset_reg;
            end
            default:
            begin
                power_next = power_reg;
            end
        endcase
        table_we = table_we && cmd.exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            shift_code_reg   <= '0;
            last_key_reg     <= '0;
            repeat_count_reg <= '0;
            long_seen_reg    <= 1'b0;
            holding_reg      <= 1'b0;
            pstrobe_reg      <= 1'b0;
            power_reg        <= kkee_pkg::POWER_RESET;
        end
        else if (cmd.exec)
        begin
            entry_count_reg  <= entry_count_next;
            shift_code_reg   <= shift_code_next;
            last_key_reg     <= last_key_next;
            repeat_count_reg <= repeat_count_next;
            long_seen_reg    <= long_seen_next;
            holding_reg      <= holding_next;
            pstrobe_reg      <= pstrobe_next;
            power_reg        <= power_next;
        end
    end

    assign emit         = emit_reg;
    assign emitted_code = code_reg;
    assign strobe_hold  = strobe_reg;
    assign power_level  = out_power_reg;

endmodule

>>> rtl/kkee_ctrl.sv
// Controller: sequences capture, table search, update and result transfer.
module kkee_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  kkee_pkg::dp_status_t  status,
    output kkee_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.mode == kkee_pkg::MODE_POLL)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the update until the result register is free
                if (slot_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/keypad_key_event_engine.sv
// Keypad key event engine: top level with configuration register and checks.
//
// Input channel (in_valid/in_ready) carries one item: mode, scan_code, key_char,
// key_kind and power_setting. Output channel (out_valid/out_ready) returns
// exactly one result per item: emit, emitted_code, strobe_hold, power_level.
// One item is worked at a time. An add, clear or set-power item passes from
// capture through the start and update states to the result register. A poll
// searches the key table newest entry first, one table RAM read per cycle,
// until it finds a match or has read every entry; a poll with scan code 0 or
// against an empty table ends its search without reading the table.
// The result sits in an output register: the next item is accepted while it
// waits, and its update is held until the waiting result is transferred.
// Reset clears all control and hold state, empties the table (entry count 0,
// no clearing pass needed), sets power to 10 and disables power keys.
// APB register 0 (power_keys_enable, bit 0) must be written only while idle,
// which the block itself does not enforce; pready is always high.
`include "keypad_key_event_engine_defines.svh"

module keypad_key_event_engine #(
    parameter int TABLE_DEPTH = kkee_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [kkee_pkg::SCAN_W-1:0]   scan_code,
    input  logic [kkee_pkg::CHAR_W-1:0]   key_char,
    input  logic [7:0]                    key_kind,
    input  logic [kkee_pkg::POWER_W-1:0]  power_setting,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          emit,
    output logic [kkee_pkg::CHAR_W-1:0]   emitted_code,
    output logic                          strobe_hold,
    output logic [kkee_pkg::POWER_W-1:0]  power_level,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    kkee_pkg::dp_cmd_t    cmd;
    kkee_pkg::dp_status_t status;
    logic                 pke_reg;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {31'd0, pke_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pke_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            pke_reg <= pwdata[0];
        end
    end

    kkee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    kkee_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .power_keys_enable (pke_reg),
        .mode              (mode),
        .scan_code         (scan_code),
        .key_char          (key_char),
        .key_kind          (key_kind),
        .power_setting     (power_setting),
        .emit              (emit),
        .emitted_code      (emitted_code),
        .strobe_hold       (strobe_hold),
        .power_level       (power_level)
    );

    `KKEE_ASSERT_IMP(a_no_code_without_emit, clk, rst_n,
        out_valid && !emit, emitted_code == 8'd0)
    `KKEE_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n,
        in_valid && in_ready, !in_ready)
    `KKEE_ASSERT_IMP(a_update_only_when_slot_free, clk, rst_n,
        cmd.exec, !out_valid || out_ready)

endmodule
